FILE: design/i2r_pkg.sv
// ----------------------------------------------------------------------------
// i2r_pkg
// Types, symbol codes and the microcode program of the integer to Roman
// numeral encoder.
// ----------------------------------------------------------------------------
package i2r_pkg;

  localparam int unsigned VALUE_W  = 12;
  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned WEIGHT_W = 10;
  localparam int unsigned PC_W     = 5;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

  // ASCII codes of the numerals
  localparam logic [SYMBOL_W-1:0] SYM_NONE = 8'h00;
  localparam logic [SYMBOL_W-1:0] SYM_I    = 8'h49;
  localparam logic [SYMBOL_W-1:0] SYM_V    = 8'h56;
  localparam logic [SYMBOL_W-1:0] SYM_X    = 8'h58;
  localparam logic [SYMBOL_W-1:0] SYM_L    = 8'h4C;
  localparam logic [SYMBOL_W-1:0] SYM_C    = 8'h43;
  localparam logic [SYMBOL_W-1:0] SYM_D    = 8'h44;
  localparam logic [SYMBOL_W-1:0] SYM_M    = 8'h4D;

  // Microcode operations
  //   OP_REP  : while remainder >= weight emit symbol and subtract, else advance
  //   OP_ONCE : if remainder >= weight emit symbol and subtract; advance
  //   OP_HEAD : if remainder >= weight emit symbol and advance, else jump
  //   OP_TAIL : emit symbol, subtract weight, advance
  typedef enum logic [1:0] {
    OP_REP  = 2'd0,
    OP_ONCE = 2'd1,
    OP_HEAD = 2'd2,
    OP_TAIL = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [WEIGHT_W-1:0] weight;
    logic [SYMBOL_W-1:0] symbol;
    logic [PC_W-1:0]     jump;
  } ucode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_ERR  = 2'd2
  } seq_state_t;

  // Control from the top level into the sequencer
  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] value;
    logic               advance;
  } seq_ctl_t;

  // One character leaving the sequencer
  typedef struct packed {
    logic                valid;
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
    logic                error;
  } emit_t;

  localparam logic [PC_W-1:0] PC_LAST = 5'd18;

  // Greedy subtractive program: 1000, 900, 500, 400, 100, 90, 50, 40, 10,
  // 9, 5, 4, 1; two-character forms take a head and a tail step.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      5'd0:    w = '{OP_REP,  10'd1000, SYM_M, 5'd0};
      5'd1:    w = '{OP_HEAD, 10'd900,  SYM_C, 5'd3};
      5'd2:    w = '{OP_TAIL, 10'd900,  SYM_M, 5'd0};
      5'd3:    w = '{OP_ONCE, 10'd500,  SYM_D, 5'd0};
      5'd4:    w = '{OP_HEAD, 10'd400,  SYM_C, 5'd6};
      5'd5:    w = '{OP_TAIL, 10'd400,  SYM_D, 5'd0};
      5'd6:    w = '{OP_REP,  10'd100,  SYM_C, 5'd0};
      5'd7:    w = '{OP_HEAD, 10'd90,   SYM_X, 5'd9};
      5'd8:    w = '{OP_TAIL, 10'd90,   SYM_C, 5'd0};
      5'd9:    w = '{OP_ONCE, 10'd50,   SYM_L, 5'd0};
      5'd10:   w = '{OP_HEAD, 10'd40,   SYM_X, 5'd12};
      5'd11:   w = '{OP_TAIL, 10'd40,   SYM_L, 5'd0};
      5'd12:   w = '{OP_REP,  10'd10,   SYM_X, 5'd0};
      5'd13:   w = '{OP_HEAD, 10'd9,    SYM_I, 5'd15};
      5'd14:   w = '{OP_TAIL, 10'd9,    SYM_X, 5'd0};
      5'd15:   w = '{OP_ONCE, 10'd5,    SYM_V, 5'd0};
      5'd16:   w = '{OP_HEAD, 10'd4,    SYM_I, 5'd18};
      5'd17:   w = '{OP_TAIL, 10'd4,    SYM_V, 5'd0};
      default: w = '{OP_REP,  10'd1,    SYM_I, PC_LAST};
    endcase
    return w;
  endfunction

endpackage

FILE: design/i2r_if.sv
// ----------------------------------------------------------------------------
// i2r_if
// Handshake channels of the encoder: integer in, numeral characters out.
// ----------------------------------------------------------------------------
interface i2r_value_if;
  logic                           valid;
  logic                           ready;
  logic [i2r_pkg::VALUE_W-1:0]    value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2r_symbol_if;
  logic                           valid;
  logic                           ready;
  logic [i2r_pkg::SYMBOL_W-1:0]   symbol;
  logic                           last;
  logic                           error;

  modport source (output valid, output symbol, output last, output error, input ready);
  modport sink   (input valid, input symbol, input last, input error, output ready);
endinterface

FILE: design/i2r_sequencer.sv
// ----------------------------------------------------------------------------
// i2r_sequencer
// Microcoded sequencer: a step counter walks the program table, one control
// word per unstalled cycle compares and subtracts against the rem register.
// ----------------------------------------------------------------------------
module i2r_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  i2r_pkg::seq_ctl_t ctl,
  output i2r_pkg::emit_t    emit,
  output logic              busy
);

  i2r_pkg::seq_state_t            state;
  i2r_pkg::seq_state_t            state_next;
  logic [i2r_pkg::PC_W-1:0]       pc;
  logic [i2r_pkg::PC_W-1:0]       pc_next;
  logic [i2r_pkg::VALUE_W-1:0]    rem;
  logic [i2r_pkg::VALUE_W-1:0]    rem_next;

  i2r_pkg::ucode_t                uw;
  logic [i2r_pkg::VALUE_W-1:0]    weight;
  logic [i2r_pkg::VALUE_W-1:0]    diff;
  logic                           ge;
  logic                           bad_value;

  // Decode the current control word
  always_comb begin
    uw     = i2r_pkg::ucode_rom(pc);
    weight = {{(i2r_pkg::VALUE_W - i2r_pkg::WEIGHT_W){1'b0}}, uw.weight};
    diff   = rem - weight;
    ge     = (rem >= weight);
    bad_value = (ctl.value == '0) || (ctl.value > i2r_pkg::VALUE_MAX);
  end

  // State, step counter and remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2r_pkg::ST_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
    rem <= rem_next;
  end

  // Next step and character emission
  always_comb begin
    state_next  = state;
    pc_next     = pc;
    rem_next    = rem;
    emit.valid  = 1'b0;
    emit.symbol = uw.symbol;
    emit.last   = 1'b0;
    emit.error  = 1'b0;
    busy        = (state != i2r_pkg::ST_IDLE);

    unique case (state)
      i2r_pkg::ST_IDLE: begin
        if (ctl.start) begin
          pc_next    = '0;
          rem_next   = ctl.value;
          state_next = bad_value ? i2r_pkg::ST_ERR : i2r_pkg::ST_RUN;
        end
      end
      i2r_pkg::ST_ERR: begin
        if (ctl.advance) begin
          emit.valid  = 1'b1;
          emit.symbol = i2r_pkg::SYM_NONE;
          emit.last   = 1'b1;
          emit.error  = 1'b1;
          state_next  = i2r_pkg::ST_IDLE;
        end
      end
      i2r_pkg::ST_RUN: begin
        if (ctl.advance) begin
          unique case (uw.op)
            i2r_pkg::OP_REP: begin
              if (ge) begin
                emit.valid = 1'b1;
                emit.last  = (diff == '0);
                rem_next   = diff;
              end else begin
                pc_next = pc + 1'b1;
              end
            end
            i2r_pkg::OP_ONCE: begin
              if (ge) begin
                emit.valid = 1'b1;
                emit.last  = (diff == '0);
                rem_next   = diff;
              end
              pc_next = pc + 1'b1;
            end
            i2r_pkg::OP_HEAD: begin
              if (ge) begin
                emit.valid = 1'b1;
                pc_next    = pc + 1'b1;
              end else begin
                pc_next = uw.jump;
              end
            end
            i2r_pkg::OP_TAIL: begin
              emit.valid = 1'b1;
              emit.last  = (diff == '0);
              rem_next   = diff;
              pc_next    = pc + 1'b1;
            end
            default: pc_next = pc;
          endcase
          // Finish once the remainder is spent
          if (emit.last) begin
            state_next = i2r_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = i2r_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: design/integer_to_roman_encoder.sv
// ----------------------------------------------------------------------------
// integer_to_roman_encoder
// Converts an integer from 1 to 3999 into its Roman numeral, one ASCII
// character per transfer, flagging the last; out-of-range values give one
// error transfer.
// ----------------------------------------------------------------------------
//  channel  modport  payload                        role
//  num      sink     value[11:0]                    integer to convert
//  sym      source   symbol[7:0], last, error       one numeral character
//
//  A value is accepted, then one program step runs per cycle while the output
//  can take a character: one step per character plus one per untaken
//  microcode step (3888: 15 characters and 9 untaken steps).
//  An out-of-range value is accepted, then gives its error transfer.
//  Reset clears the sequencer state and the output valid; nothing needs a sweep.
//  The sequencer holds while the output register is full and not taken; the
//  next value is taken as soon as the last character sits in that register.
// ----------------------------------------------------------------------------
module integer_to_roman_encoder (
  input  logic                clk,
  input  logic                rst,
  i2r_value_if.sink           num,
  i2r_symbol_if.source        sym
);

  i2r_pkg::seq_ctl_t            ctl;
  i2r_pkg::emit_t               emit;
  logic                         busy;

  logic                         out_valid;
  logic [i2r_pkg::SYMBOL_W-1:0] out_symbol;
  logic                         out_last;
  logic                         out_error;

  // Drive the sequencer
  always_comb begin
    num.ready   = !busy;
    ctl.start   = num.valid && !busy;
    ctl.value   = num.value;
    ctl.advance = !out_valid || sym.ready;
  end

  i2r_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .emit (emit),
    .busy (busy)
  );

  // Output register: load a new character, drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (sym.ready) begin
      out_valid <= 1'b0;
    end
    if (emit.valid) begin
      out_symbol <= emit.symbol;
      out_last   <= emit.last;
      out_error  <= emit.error;
    end
  end

  assign sym.valid  = out_valid;
  assign sym.symbol = out_symbol;
  assign sym.last   = out_last;
  assign sym.error  = out_error;

  // Error transfer is a single closing character with no symbol
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (sym.valid && sym.error) |-> (sym.last && (sym.symbol == i2r_pkg::SYM_NONE)))
    else $error("error transfer without last or with a symbol");

  // A character is only produced when the output register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> (!out_valid || sym.ready))
    else $error("sequencer overwrote a pending character");

  // A pending non-final character means the value is still being worked on
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    (sym.valid && !sym.last) |-> busy)
    else $error("sequencer idle in the middle of a numeral");

  // An accepted value occupies the sequencer in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (num.valid && num.ready) |=> busy)
    else $error("accepted value did not start the sequencer");

endmodule
